>>> hdl/hid_boot_keyboard_report_builder_macros.svh
// Assertion macros shared by the keyboard report builder RTL.
`ifndef HID_BOOT_KEYBOARD_REPORT_BUILDER_MACROS_SVH
`define HID_BOOT_KEYBOARD_REPORT_BUILDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HBK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hbk_pkg.sv
// Shared constants, types and the key code to usage table.
`timescale 1ns / 1ps
package hbk_pkg;

  localparam int MAX_HELD_DEF       = 16;
  localparam int REPORT_SLOTS_DEF   = 6;
  localparam int KEY_CODE_COUNT_DEF = 128;
  localparam int OUT_SLOTS          = 6;

  localparam logic [7:0] MOD_FIRST      = 8'hE0;
  localparam logic [7:0] MOD_LAST       = 8'hE7;
  localparam logic [7:0] ROLLOVER_USAGE = 8'h01;
  localparam logic [7:0] NO_USAGE       = 8'h00;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       clear;   // capture match flags, reset the wave
    logic       step;    // advance the match wave by one cell
    logic       apply;   // commit the list update
    logic       rel;     // release: close the gap behind a match
    logic       ins;     // press: append at the fill position
    logic [7:0] usage;
  } hbk_cell_ctrl_t;

  // Key code to usage for codes 0..127.
  localparam logic [7:0] USAGE_ROM [128] = '{
    8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b,
    8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c,
    8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'he0, 8'h04, 8'h16,
    8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
    8'h34, 8'h35, 8'he1, 8'h31, 8'h1d, 8'h1b, 8'h06, 8'h19,
    8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'he5, 8'h55,
    8'he2, 8'h2c, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
    8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5f,
    8'h60, 8'h61, 8'h56, 8'h5c, 8'h5d, 8'h5e, 8'h57, 8'h59,
    8'h5a, 8'h5b, 8'h62, 8'h63, 8'h00, 8'h94, 8'h64, 8'h44,
    8'h45, 8'h87, 8'h92, 8'h93, 8'h8a, 8'h88, 8'h8b, 8'h8c,
    8'h58, 8'he4, 8'h54, 8'h46, 8'he6, 8'h00, 8'h4a, 8'h52,
    8'h4b, 8'h50, 8'h4f, 8'h4d, 8'h51, 8'h4e, 8'h49, 8'h4c,
    8'h00, 8'h7f, 8'h81, 8'h80, 8'h66, 8'h67, 8'hd7, 8'h48,
    8'h00, 8'h85, 8'h90, 8'h91, 8'h89, 8'he3, 8'he7, 8'h65
  };

  // Look up a usage; codes 128 and up map to no usage.
  function automatic logic [7:0] usage_of(input logic [7:0] code);
    logic [7:0] u;
    if (code[7]) begin
      u = NO_USAGE;
    end else begin
      u = USAGE_ROM[code[6:0]];
    end
    return u;
  endfunction

endpackage

>>> hdl/hbk_if.sv
// Handshake channels for key events and boot reports.
`timescale 1ns / 1ps
interface hbk_evt_if;
  logic        valid;
  logic        ready;
  logic        is_down;
  logic [15:0] ev_code;

  modport source (output valid, output is_down, output ev_code, input ready);
  modport sink   (input valid, input is_down, input ev_code, output ready);
endinterface

interface hbk_rpt_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] slot_0;
  logic [7:0] slot_1;
  logic [7:0] slot_2;
  logic [7:0] slot_3;
  logic [7:0] slot_4;
  logic [7:0] slot_5;

  modport source (output valid, output modifier_bits, output slot_0, output slot_1,
                  output slot_2, output slot_3, output slot_4, output slot_5,
                  input ready);
  modport sink   (input valid, input modifier_bits, input slot_0, input slot_1,
                  input slot_2, input slot_3, input slot_4, input slot_5,
                  output ready);
endinterface

>>> hdl/hid_boot_keyboard_report_builder.sv
// Boot keyboard report builder: key events in, 8-byte boot reports out.
//
// evt_i carries one key event per beat (is_down, ev_code). rpt_o carries
// one boot report per beat: modifier_bits and six key slots; the reserved
// byte is always zero and not carried.
// Codes at or above KEY_CODE_COUNT, and codes with no usage, are taken
// and dropped with no report.
// A modifier event updates its modifier bit and goes straight to the report state.
// A key event walks a match wave down a row of MAX_HELD cells, one cell a
// cycle, then commits the list update and builds its report. evt_i is
// not ready again until that report is loaded into the output register.
// The report sits in an output register; evt_i is taken again while a
// report waits there. If rpt_o stalls with a report pending, the next
// report waits in the build stage and evt_i holds off.
// Reset empties the held list and clears the modifier byte; the list
// entries themselves are not cleared.
`timescale 1ns / 1ps
`include "hid_boot_keyboard_report_builder_macros.svh"
module hid_boot_keyboard_report_builder #(
  parameter int MAX_HELD       = hbk_pkg::MAX_HELD_DEF,
  parameter int REPORT_SLOTS   = hbk_pkg::REPORT_SLOTS_DEF,
  parameter int KEY_CODE_COUNT = hbk_pkg::KEY_CODE_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hbk_evt_if.sink   evt_i,
  hbk_rpt_if.source rpt_o
);

  localparam int CW = $clog2(MAX_HELD + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_PROP  = 5'b00100,
    S_APPLY = 5'b01000,
    S_RPT   = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] prop_q, prop_d;
  logic [CW-1:0] held_cnt_q, held_cnt_d;
  logic [7:0]    mod_q, mod_d;
  logic [7:0]    usage_q, usage_d;
  logic          press_q, press_d;

  logic [7:0] entry [MAX_HELD];
  logic       carry [MAX_HELD];

  logic       evt_take;
  logic       in_range;
  logic [7:0] in_usage;
  logic       is_mod;
  logic       any_hit;
  logic       do_ins;
  logic       do_rel;
  logic       rpt_load;

  hbk_pkg::hbk_cell_ctrl_t ctrl;

  logic       out_valid_q;
  logic [7:0] out_mod_q;
  logic [7:0] out_slot_q [hbk_pkg::OUT_SLOTS];
  logic [7:0] slot_d [hbk_pkg::OUT_SLOTS];

  // Decode the incoming event.
  assign evt_i.ready = (state_q == S_IDLE);
  assign evt_take    = evt_i.valid && evt_i.ready;
  assign in_range    = (evt_i.ev_code < 16'(KEY_CODE_COUNT));
  assign in_usage    = hbk_pkg::usage_of(evt_i.ev_code[7:0]);
  assign is_mod      = (in_usage >= hbk_pkg::MOD_FIRST) && (in_usage <= hbk_pkg::MOD_LAST);

  // List update decisions, valid once the wave has settled.
  assign any_hit = carry[MAX_HELD-1];
  assign do_ins  = press_q && !any_hit && (held_cnt_q < CW'(MAX_HELD));
  assign do_rel  = !press_q && any_hit;

  assign ctrl.clear = (state_q == S_CMP);
  assign ctrl.step  = (state_q == S_PROP);
  assign ctrl.apply = (state_q == S_APPLY);
  assign ctrl.rel   = !press_q;
  assign ctrl.ins   = do_ins;
  assign ctrl.usage = usage_q;

  assign rpt_load = (state_q == S_RPT) && (!out_valid_q || rpt_o.ready);

  // Row of cells; the match wave flows toward the tail, entries toward the head.
  for (genvar g = 0; g < MAX_HELD; g++) begin : g_cell
    logic       seen_in;
    logic [7:0] next_in;
    if (g == 0) begin : g_head
      assign seen_in = 1'b0;
    end else begin : g_body
      assign seen_in = carry[g-1];
    end
    if (g == MAX_HELD - 1) begin : g_tail
      assign next_in = entry[g];
    end else begin : g_mid
      assign next_in = entry[g+1];
    end
    hbk_cell #(
      .MAX_HELD (MAX_HELD),
      .IDX      (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (held_cnt_q),
      .seen_i       (seen_in),
      .next_entry_i (next_in),
      .carry_o      (carry[g]),
      .entry_o      (entry[g])
    );
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    prop_d     = prop_q;
    held_cnt_d = held_cnt_q;
    mod_d      = mod_q;
    usage_d    = usage_q;
    press_d    = press_q;
    unique case (state_q)
      S_IDLE: begin
        if (evt_take && in_range && (in_usage != hbk_pkg::NO_USAGE)) begin
          if (is_mod) begin
            mod_d[in_usage[2:0]] = evt_i.is_down;
            state_d = S_RPT;
          end else begin
            usage_d = in_usage;
            press_d = evt_i.is_down;
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        prop_d  = '0;
        state_d = S_PROP;
      end
      S_PROP: begin
        prop_d = prop_q + 1'b1;
        if (prop_q == CW'(MAX_HELD - 1)) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (do_ins) begin
          held_cnt_d = held_cnt_q + 1'b1;
        end else if (do_rel) begin
          held_cnt_d = held_cnt_q - 1'b1;
        end
        state_d = S_RPT;
      end
      S_RPT: begin
        if (rpt_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      prop_q     <= '0;
      held_cnt_q <= '0;
      mod_q      <= '0;
      press_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      prop_q     <= prop_d;
      held_cnt_q <= held_cnt_d;
      mod_q      <= mod_d;
      press_q    <= press_d;
    end
  end

  always_ff @(posedge clk_i) begin
    usage_q <= usage_d;
  end

  // Build the key slots from the head of the list.
  always_comb begin
    for (int i = 0; i < hbk_pkg::OUT_SLOTS; i++) begin
      slot_d[i] = hbk_pkg::NO_USAGE;
      if (i < REPORT_SLOTS) begin
        if (held_cnt_q > CW'(REPORT_SLOTS)) begin
          slot_d[i] = hbk_pkg::ROLLOVER_USAGE;
        end else if (CW'(i) < held_cnt_q) begin
          slot_d[i] = entry[i];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rpt_load) begin
      out_valid_q <= 1'b1;
    end else if (rpt_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpt_load) begin
      out_mod_q  <= mod_q;
      out_slot_q <= slot_d;
    end
  end

  assign rpt_o.valid         = out_valid_q;
  assign rpt_o.modifier_bits = out_mod_q;
  assign rpt_o.slot_0        = out_slot_q[0];
  assign rpt_o.slot_1        = out_slot_q[1];
  assign rpt_o.slot_2        = out_slot_q[2];
  assign rpt_o.slot_3        = out_slot_q[3];
  assign rpt_o.slot_4        = out_slot_q[4];
  assign rpt_o.slot_5        = out_slot_q[5];

  // Checks on the list bookkeeping.
  `HBK_ASSERT_NOW(a_ins_room, (state_q == S_APPLY) && do_ins, held_cnt_q < CW'(MAX_HELD), "append into a full list")
  `HBK_ASSERT_NEXT(a_rel_count, (state_q == S_APPLY) && do_rel, held_cnt_q == $past(held_cnt_q) - 1'b1, "release did not shrink the list")
  `HBK_ASSERT_NOW(a_cnt_bound, state_q != S_APPLY, held_cnt_q <= CW'(MAX_HELD), "held count beyond list depth")
  `HBK_ASSERT_NEXT(a_key_walk, evt_take && in_range && (in_usage != hbk_pkg::NO_USAGE) && !is_mod, state_q == S_CMP, "key event did not start the walk")

endmodule

>>> hdl/hbk_cell.sv
// One held-list cell: an entry, its match flag and the match wave stage.
`timescale 1ns / 1ps
module hbk_cell #(
  parameter int MAX_HELD = hbk_pkg::MAX_HELD_DEF,
  parameter int IDX      = 0,
  localparam int CW      = $clog2(MAX_HELD + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hbk_pkg::hbk_cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]          count_i,
  input  logic                   seen_i,
  input  logic [7:0]             next_entry_i,
  output logic                   carry_o,
  output logic [7:0]             entry_o
);

  logic [7:0] entry_q;
  logic       hit_q;
  logic       seen_q;
  logic       here;

  assign here    = (count_i == CW'(IDX));
  assign carry_o = seen_q | hit_q;
  assign entry_o = entry_q;

  // Match flag and the wave of "a match lies before this cell".
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      seen_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      hit_q  <= (entry_q == ctrl_i.usage) && (CW'(IDX) < count_i);
      seen_q <= 1'b0;
    end else if (ctrl_i.step) begin
      seen_q <= seen_i;
    end
  end

  // Append at the fill position, or pull the neighbor in behind a release.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      if (ctrl_i.ins && here) begin
        entry_q <= ctrl_i.usage;
      end else if (ctrl_i.rel && (seen_q || hit_q)) begin
        entry_q <= next_entry_i;
      end
    end
  end

endmodule
